// ===== src/lavm_pkg.sv =====
// lavm_pkg: shared constants, payload structs and small tables for the look-at view matrix block
// used by every module under src, no dependencies
package lavm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int SW        = 31;
  localparam int MW        = 61;
  localparam int RW        = 62;
  localparam int SQW       = 62;
  localparam int RTW       = 31;
  localparam int UW        = FRAC_BITS + 2;
  localparam int NW        = 30 + FRAC_BITS + 1;
  localparam int AW        = FRAC_BITS + 34;
  localparam int CW        = 5;

  typedef struct packed {
    logic signed [DW-1:0] eye_x;
    logic signed [DW-1:0] eye_y;
    logic signed [DW-1:0] eye_z;
    logic signed [DW-1:0] target_x;
    logic signed [DW-1:0] target_y;
    logic signed [DW-1:0] target_z;
    logic signed [DW-1:0] hint_up_x;
    logic signed [DW-1:0] hint_up_y;
    logic signed [DW-1:0] hint_up_z;
  } lavm_in_t;

  typedef struct packed {
    logic signed [DW-1:0] side_x;
    logic signed [DW-1:0] side_y;
    logic signed [DW-1:0] side_z;
    logic signed [DW-1:0] true_up_x;
    logic signed [DW-1:0] true_up_y;
    logic signed [DW-1:0] true_up_z;
    logic signed [DW-1:0] back_x;
    logic signed [DW-1:0] back_y;
    logic signed [DW-1:0] back_z;
    logic signed [DW-1:0] shift_x;
    logic signed [DW-1:0] shift_y;
    logic signed [DW-1:0] shift_z;
  } lavm_out_t;

  typedef struct packed {
    logic [2:0][DW-1:0] eye;
    logic [2:0][DW:0]   fwd_mag;
    logic [2:0]         fwd_neg;
    logic [2:0][DW-1:0] up_mag;
    logic [2:0]         up_neg;
  } lavm_item_t;

  // operand order of the six cross product terms
  function automatic logic [1:0] cross_a(input logic [2:0] j);
    logic [1:0] r;
    unique case (j)
      3'd0: r = 2'd1;
      3'd1: r = 2'd2;
      3'd2: r = 2'd2;
      3'd3: r = 2'd0;
      3'd4: r = 2'd0;
      3'd5: r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cross_b(input logic [2:0] j);
    logic [1:0] r;
    unique case (j)
      3'd0: r = 2'd2;
      3'd1: r = 2'd1;
      3'd2: r = 2'd0;
      3'd3: r = 2'd2;
      3'd4: r = 2'd1;
      3'd5: r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/lavm_front.sv =====
// lavm_front: takes input transfers, forms forward = target - eye and splits vectors
// into magnitude and sign for the queue; depends on lavm_pkg
module lavm_front (
  input  lavm_pkg::lavm_in_t   in_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 full_i,
  output logic                 push_o,
  output lavm_pkg::lavm_item_t item_o
);
  import lavm_pkg::*;

  logic signed [DW-1:0] eye [3];
  logic signed [DW-1:0] tgt [3];
  logic signed [DW-1:0] up  [3];
  logic signed [DW:0]   fwd [3];

  always_comb begin
    eye[0] = in_data_i.eye_x;
    eye[1] = in_data_i.eye_y;
    eye[2] = in_data_i.eye_z;
    tgt[0] = in_data_i.target_x;
    tgt[1] = in_data_i.target_y;
    tgt[2] = in_data_i.target_z;
    up[0]  = in_data_i.hint_up_x;
    up[1]  = in_data_i.hint_up_y;
    up[2]  = in_data_i.hint_up_z;
    for (int i = 0; i < 3; i++) begin
      fwd[i]            = (DW+1)'(tgt[i]) - (DW+1)'(eye[i]);
      item_o.eye[i]     = eye[i];
      item_o.fwd_neg[i] = fwd[i][DW];
      item_o.fwd_mag[i] = fwd[i][DW] ? (DW+1)'(-fwd[i]) : (DW+1)'(fwd[i]);
      item_o.up_neg[i]  = up[i][DW-1];
      item_o.up_mag[i]  = up[i][DW-1] ? DW'(-up[i]) : DW'(up[i]);
    end
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// ===== src/lavm_fifo.sv =====
// lavm_fifo: two-entry queue between front and back
// depends on lavm_pkg
module lavm_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lavm_pkg::lavm_item_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output lavm_pkg::lavm_item_t data_o
);
  import lavm_pkg::*;

  lavm_item_t mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      if (push_i && !pop_i) cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

// ===== src/lavm_back.sv =====
// lavm_back: sequencer with one shared multiplier, block scaler, bit-serial square root
// and divider; builds the view matrix rows and holds the result register; depends on lavm_pkg
module lavm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  lavm_pkg::lavm_item_t q_item_i,
  output logic                 q_pop_o,
  output lavm_pkg::lavm_out_t  out_data_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i
);
  import lavm_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MAX  = 4'd1;
  localparam logic [3:0] ST_SCL  = 4'd2;
  localparam logic [3:0] ST_STO  = 4'd3;
  localparam logic [3:0] ST_CRS  = 4'd4;
  localparam logic [3:0] ST_LDR  = 4'd5;
  localparam logic [3:0] ST_SQ   = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_DVI  = 4'd8;
  localparam logic [3:0] ST_DIV  = 4'd9;
  localparam logic [3:0] ST_DOT  = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  localparam logic [3:0] PH_FWD  = 4'd0;
  localparam logic [3:0] PH_UP   = 4'd1;
  localparam logic [3:0] PH_CR1  = 4'd2;
  localparam logic [3:0] PH_SIDE = 4'd3;
  localparam logic [3:0] PH_CR2  = 4'd4;
  localparam logic [3:0] PH_TUP  = 4'd5;
  localparam logic [3:0] PH_UF   = 4'd6;
  localparam logic [3:0] PH_US   = 4'd7;
  localparam logic [3:0] PH_UT   = 4'd8;

  logic [3:0]    st_q;
  logic [3:0]    ph_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]    dc_q;
  logic [1:0]    dk_q;
  logic          out_valid_q;
  lavm_out_t     out_q;

  logic signed [DW-1:0]  eye_q [3];
  logic [DW-1:0]         upm_q [3];
  logic                  upn_q [3];
  logic [MW-1:0]         wm_q  [3];
  logic                  wn_q  [3];
  logic [MW-1:0]         mx_q;
  logic signed [SW-1:0]  fs_q  [3];
  logic signed [SW-1:0]  us_q  [3];
  logic signed [SW-1:0]  ss_q  [3];
  logic signed [SW-1:0]  ts_q  [3];
  logic signed [RW-1:0]  raw_q [3];
  logic signed [63:0]    p_q;
  logic [SQW-1:0]        sq_q;
  logic [SQW-1:0]        rad_q;
  logic [31:0]           rem_q;
  logic [RTW-1:0]        root_q;
  logic [RTW-1:0]        dr_q;
  logic [FRAC_BITS:0]    dn_q;
  logic [FRAC_BITS:0]    q_q;
  logic signed [UW-1:0]  fu_q  [3];
  logic signed [UW-1:0]  su_q  [3];
  logic signed [UW-1:0]  uu_q  [3];
  logic signed [AW-1:0]  acc_q;
  logic signed [DW-1:0]  tr_q  [3];

  logic signed [SW-1:0]  va   [3];
  logic signed [SW-1:0]  vb   [3];
  logic signed [SW-1:0]  usrc [3];
  logic signed [UW-1:0]  udot [3];
  logic signed [SW-1:0]  wsc  [3];
  logic [1:0]            j3;
  logic signed [DW-1:0]  mul_a;
  logic signed [DW-1:0]  mul_b;
  logic signed [63:0]    prod;
  logic [MW-1:0]         m01;
  logic [MW-1:0]         mxn;
  logic [5:0]            sk;
  logic                  sh_r;
  logic                  sh_l;
  logic [2:0]            ct;
  logic [33:0]           cur_s;
  logic [33:0]           trial_s;
  logic                  ge_s;
  logic signed [SW-1:0]  mgs;
  logic [29:0]           mg;
  logic [NW-1:0]         num;
  logic [31:0]           cur_d;
  logic                  ge_d;
  logic [FRAC_BITS:0]    qf;
  logic signed [UW-1:0]  uq;
  logic signed [AW-1:0]  ed;
  logic [AW-1:0]         em;
  logic [AW-1:0]         sr;
  logic [AW-FRAC_BITS-1:0] rr;
  logic [AW-FRAC_BITS-1:0] nr;
  logic signed [DW-1:0]  tv;
  logic                  out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign q_pop_o     = (st_q == ST_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = (ph_q == PH_CR1) ? fs_q[i] : ss_q[i];
      vb[i] = (ph_q == PH_CR1) ? us_q[i] : fs_q[i];
      if (ph_q == PH_UF) usrc[i] = fs_q[i];
      else if (ph_q == PH_US) usrc[i] = ss_q[i];
      else usrc[i] = ts_q[i];
      if (dk_q == 2'd0) udot[i] = su_q[i];
      else if (dk_q == 2'd1) udot[i] = uu_q[i];
      else udot[i] = fu_q[i];
      wsc[i] = wn_q[i] ? -SW'(wm_q[i][29:0]) : SW'(wm_q[i][29:0]);
    end
  end

  // shared multiplier operand select
  always_comb begin
    j3 = (cnt_q < CW'(3)) ? cnt_q[1:0] : 2'd0;
    unique case (st_q)
      ST_CRS: begin
        mul_a = DW'(va[cross_a(cnt_q[2:0])]);
        mul_b = DW'(vb[cross_b(cnt_q[2:0])]);
      end
      ST_SQ: begin
        mul_a = DW'(usrc[j3]);
        mul_b = DW'(usrc[j3]);
      end
      ST_DOT: begin
        mul_a = DW'(udot[j3]);
        mul_b = eye_q[j3];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // block scaling and cross product helpers
  always_comb begin
    m01  = (wm_q[0] > wm_q[1]) ? wm_q[0] : wm_q[1];
    mxn  = (m01 > wm_q[2]) ? m01 : wm_q[2];
    sk   = 6'd32 >> cnt_q[2:0];
    sh_r = (mx_q >> (7'd29 + 7'(sk))) != '0;
    sh_l = (sk < 6'd30) && (mx_q != '0) && ((mx_q >> (6'd30 - sk)) == '0);
    ct   = 3'(cnt_q - CW'(1));
  end

  // square root, divider and rounding helpers
  always_comb begin
    cur_s   = {rem_q, rad_q[SQW-1 -: 2]};
    trial_s = {1'b0, root_q, 2'b01};
    ge_s    = cur_s >= trial_s;
    mgs     = usrc[dc_q][SW-1] ? -usrc[dc_q] : usrc[dc_q];
    mg      = mgs[29:0];
    num     = NW'({mg, {FRAC_BITS{1'b0}}}) + NW'(root_q >> 1);
    cur_d   = {dr_q, dn_q[FRAC_BITS]};
    ge_d    = cur_d >= {1'b0, root_q};
    qf      = {q_q[FRAC_BITS-1:0], ge_d};
    if (root_q == '0) uq = '0;
    else if (usrc[dc_q][SW-1]) uq = -UW'(qf);
    else uq = UW'(qf);
    ed = (dk_q != 2'd2) ? -acc_q : acc_q;
    em = ed[AW-1] ? AW'(-ed) : AW'(ed);
    sr = em + (AW'(1) << (FRAC_BITS - 1));
    rr = sr[AW-1:FRAC_BITS];
    nr = -rr;
    if (!ed[AW-1]) tv = (rr > (AW-FRAC_BITS)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : rr[31:0];
    else tv = (rr > (AW-FRAC_BITS)'(32'h8000_0000)) ? 32'sh8000_0000 : nr[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ph_q        <= PH_FWD;
      cnt_q       <= '0;
      dc_q        <= '0;
      dk_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            ph_q <= PH_FWD;
            st_q <= ST_MAX;
          end
        end
        ST_MAX: begin
          cnt_q <= '0;
          st_q  <= ST_SCL;
        end
        ST_SCL: begin
          if (cnt_q == CW'(5)) st_q <= ST_STO;
          else cnt_q <= cnt_q + CW'(1);
        end
        ST_STO: begin
          cnt_q <= '0;
          unique case (ph_q)
            PH_FWD: begin
              ph_q <= PH_UP;
              st_q <= ST_MAX;
            end
            PH_UP: begin
              ph_q <= PH_CR1;
              st_q <= ST_CRS;
            end
            PH_SIDE: begin
              ph_q <= PH_CR2;
              st_q <= ST_CRS;
            end
            PH_TUP: begin
              ph_q <= PH_UF;
              st_q <= ST_SQ;
            end
            default: st_q <= ST_IDLE;
          endcase
        end
        ST_CRS: begin
          if (cnt_q == CW'(6)) begin
            ph_q <= (ph_q == PH_CR1) ? PH_SIDE : PH_TUP;
            st_q <= ST_LDR;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        ST_LDR: st_q <= ST_MAX;
        ST_SQ: begin
          if (cnt_q == CW'(3)) begin
            cnt_q <= '0;
            st_q  <= ST_SQRT;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        ST_SQRT: begin
          if (cnt_q == CW'(RTW - 1)) begin
            dc_q <= '0;
            st_q <= ST_DVI;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        ST_DVI: begin
          cnt_q <= '0;
          st_q  <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_q == CW'(FRAC_BITS)) begin
            cnt_q <= '0;
            if (dc_q == 2'd2) begin
              if (ph_q == PH_UT) begin
                dk_q <= '0;
                st_q <= ST_DOT;
              end else begin
                ph_q <= ph_q + 4'd1;
                st_q <= ST_SQ;
              end
            end else begin
              dc_q <= dc_q + 2'd1;
              st_q <= ST_DVI;
            end
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        ST_DOT: begin
          if (cnt_q == CW'(4)) begin
            cnt_q <= '0;
            if (dk_q == 2'd2) st_q <= ST_OUT;
            else dk_q <= dk_q + 2'd1;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end
        ST_OUT: begin
          if (out_free) st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          for (int i = 0; i < 3; i++) begin
            eye_q[i] <= $signed(q_item_i.eye[i]);
            upm_q[i] <= q_item_i.up_mag[i];
            upn_q[i] <= q_item_i.up_neg[i];
            wm_q[i]  <= MW'(q_item_i.fwd_mag[i]);
            wn_q[i]  <= q_item_i.fwd_neg[i];
          end
        end
      end
      ST_MAX: mx_q <= mxn;
      ST_SCL: begin
        for (int i = 0; i < 3; i++) begin
          if (sh_r) wm_q[i] <= wm_q[i] >> sk;
          else if (sh_l) wm_q[i] <= wm_q[i] << sk;
        end
        if (sh_r) mx_q <= mx_q >> sk;
        else if (sh_l) mx_q <= mx_q << sk;
      end
      ST_STO: begin
        for (int i = 0; i < 3; i++) begin
          unique case (ph_q)
            PH_FWD: begin
              fs_q[i] <= wsc[i];
              wm_q[i] <= MW'(upm_q[i]);
              wn_q[i] <= upn_q[i];
            end
            PH_UP:   us_q[i] <= wsc[i];
            PH_SIDE: ss_q[i] <= wsc[i];
            PH_TUP:  ts_q[i] <= wsc[i];
            default: ;
          endcase
        end
      end
      ST_CRS: begin
        p_q <= prod;
        if (cnt_q != '0) begin
          if (!ct[0]) raw_q[ct[2:1]] <= $signed(p_q[RW-1:0]);
          else raw_q[ct[2:1]] <= raw_q[ct[2:1]] - $signed(p_q[RW-1:0]);
        end
      end
      ST_LDR: begin
        for (int i = 0; i < 3; i++) begin
          wn_q[i] <= raw_q[i][RW-1];
          wm_q[i] <= raw_q[i][RW-1] ? MW'(-raw_q[i]) : MW'(raw_q[i]);
        end
      end
      ST_SQ: begin
        p_q <= prod;
        if (cnt_q == '0) begin
          sq_q <= '0;
        end else if (cnt_q == CW'(3)) begin
          rad_q  <= sq_q + p_q[SQW-1:0];
          rem_q  <= '0;
          root_q <= '0;
        end else begin
          sq_q <= sq_q + p_q[SQW-1:0];
        end
      end
      ST_SQRT: begin
        rem_q  <= ge_s ? 32'(cur_s - trial_s) : cur_s[31:0];
        root_q <= {root_q[RTW-2:0], ge_s};
        rad_q  <= rad_q << 2;
      end
      ST_DVI: begin
        dr_q <= RTW'(num[NW-1:FRAC_BITS+1]);
        dn_q <= num[FRAC_BITS:0];
        q_q  <= '0;
      end
      ST_DIV: begin
        dr_q <= ge_d ? RTW'(cur_d - {1'b0, root_q}) : cur_d[RTW-1:0];
        dn_q <= dn_q << 1;
        q_q  <= qf;
        if (cnt_q == CW'(FRAC_BITS)) begin
          unique case (ph_q)
            PH_UF:   fu_q[dc_q] <= uq;
            PH_US:   su_q[dc_q] <= uq;
            PH_UT:   uu_q[dc_q] <= uq;
            default: ;
          endcase
        end
      end
      ST_DOT: begin
        p_q <= prod;
        if (cnt_q == CW'(1)) acc_q <= $signed(p_q[AW-1:0]);
        else if (cnt_q == CW'(2) || cnt_q == CW'(3)) acc_q <= acc_q + $signed(p_q[AW-1:0]);
        else if (cnt_q == CW'(4)) tr_q[dk_q] <= tv;
      end
      ST_OUT: begin
        if (out_free) begin
          out_q.side_x    <= DW'(su_q[0]);
          out_q.side_y    <= DW'(su_q[1]);
          out_q.side_z    <= DW'(su_q[2]);
          out_q.true_up_x <= DW'(uu_q[0]);
          out_q.true_up_y <= DW'(uu_q[1]);
          out_q.true_up_z <= DW'(uu_q[2]);
          out_q.back_x    <= -DW'(fu_q[0]);
          out_q.back_y    <= -DW'(fu_q[1]);
          out_q.back_z    <= -DW'(fu_q[2]);
          out_q.shift_x   <= tr_q[0];
          out_q.shift_y   <= tr_q[1];
          out_q.shift_z   <= tr_q[2];
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/look_at_view_matrix_top.sv =====
// look_at_view_matrix_top: right-handed look-at view matrix in signed fixed point
// depends on lavm_pkg, lavm_front, lavm_fifo and lavm_back
//
// input channel: in_data_i carries eye, target and up hint; a transfer happens when
// in_valid_i is high and in_stall_o is low. output channel: out_data_o carries the
// three rotation rows and the saturated translations; a transfer happens when
// out_valid_o is high and out_stall_i is low. one result per input item, in order.
// the front forms target - eye and queues up to two items while the back works.
// the back runs one item at a time on a single shared 32x32 multiplier with a
// bit-serial square root and divider; its work is set by three normalizations of
// square root plus three divides each, and it takes the next queued item only
// after its result is in the output register.
// reset clears the queue, the sequencer and the output valid; no clearing pass.
// when the receiver stalls, the result holds in the output register, the back
// waits after finishing its next item, and the input stalls once the queue is full.
module look_at_view_matrix_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lavm_pkg::lavm_in_t  in_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output lavm_pkg::lavm_out_t out_data_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);
  import lavm_pkg::*;

  lavm_item_t push_item;
  lavm_item_t pop_item;
  logic       push;
  logic       full;
  logic       pop;
  logic       q_valid;

  lavm_front u_front (
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  lavm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_item)
  );

  lavm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (pop_item),
    .q_pop_o     (pop),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
